/* rtl/core/bounded_sorted_nearest_list_macros.svh */
// Assertion macros for the bounded sorted nearest list block.
// Included by the RTL files that carry concurrent checks; expects clk and rst in scope.
`ifndef BOUNDED_SORTED_NEAREST_LIST_MACROS_SVH
`define BOUNDED_SORTED_NEAREST_LIST_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BSNL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BSNL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bsnl_pkg.sv */
// Shared types and constants for the bounded sorted nearest list.
// No dependencies; used by the interfaces, the RAM users and the top level.
package bsnl_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int ID_BITS    = 10;
  localparam int KEY_BITS   = 32;
  localparam int IDX_BITS   = $clog2(LIST_DEPTH);
  localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);

  localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(LIST_DEPTH);

  // Item actions
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_PUBLISH = 2'd2,
    ACT_READ    = 2'd3
  } act_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_SHIFT,
    ST_COPY,
    ST_READ,
    ST_CAPTURE,
    ST_DONE
  } st_t;

  // One stored list entry
  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } entry_t;

endpackage

/* rtl/core/bsnl_if.sv */
// Request and response channel interfaces for the bounded sorted nearest list.
// Depends on bsnl_pkg for field widths.
interface bsnl_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [bsnl_pkg::ID_BITS-1:0]  entity_id;
  logic [bsnl_pkg::KEY_BITS-1:0] distance_key;
  logic [bsnl_pkg::IDX_BITS-1:0] read_index;

  modport source (output valid, action, entity_id, distance_key, read_index, input ready);
  modport sink (input valid, action, entity_id, distance_key, read_index, output ready);
endinterface

interface bsnl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          inserted;
  logic [bsnl_pkg::CNT_BITS-1:0] insert_position;
  logic [bsnl_pkg::CNT_BITS-1:0] working_count;
  logic [bsnl_pkg::CNT_BITS-1:0] snapshot_count;
  logic                          read_valid;
  logic [bsnl_pkg::ID_BITS-1:0]  read_entity;
  logic [bsnl_pkg::KEY_BITS-1:0] read_distance;

  modport source (output valid, inserted, insert_position, working_count, snapshot_count,
                  read_valid, read_entity, read_distance, input ready);
  modport sink (input valid, inserted, insert_position, working_count, snapshot_count,
                read_valid, read_entity, read_distance, output ready);
endinterface

/* rtl/core/bounded_sorted_nearest_list.sv */
// Steps, accept to result: a clear goes straight to done; a read goes through read and
// capture (straight to done when out of range); a publish copies each working entry; an
// insert runs a binary search of at most 7 probes, then moves each entry behind its slot
// up one place, and a dropped insert ends after the search. The input is not ready until
// the item finishes, and a finished item waits in the output register.
// Reset (rst, sync, active high) empties both lists; RAM is read only below the counts.
module bounded_sorted_nearest_list (
  input  logic           clk,
  input  logic           rst,
  bsnl_req_if.sink       req,
  bsnl_rsp_if.source     rsp
);

  `include "bounded_sorted_nearest_list_macros.svh"

  localparam int IW = bsnl_pkg::IDX_BITS;
  localparam int CW = bsnl_pkg::CNT_BITS;

  bsnl_pkg::st_t    state, state_next;
  bsnl_pkg::entry_t new_entry;
  bsnl_pkg::entry_t wl_rdata, sn_rdata;
  bsnl_pkg::entry_t wl_wdata, sn_wdata;

  logic [CW-1:0] wlen, slen;
  logic [CW-1:0] lo, hi, ptr, len_cap;
  logic [CW:0]   lo_hi_sum;
  logic [CW-1:0] mid;
  logic [IW-1:0] pend_addr, ridx;
  logic          pend;
  logic          res_ins, res_rvalid;
  logic [CW-1:0] res_pos;
  logic [bsnl_pkg::ID_BITS-1:0]  res_rid;
  logic [bsnl_pkg::KEY_BITS-1:0] res_rkey;
  logic          ovalid, out_load;

  logic          wl_we, wl_re, sn_we, sn_re;
  logic [IW-1:0] wl_waddr, wl_raddr, sn_waddr, sn_raddr;

  // Search midpoint and the length after a possible eviction
  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = lo_hi_sum[CW:1];
  assign len_cap   = (wlen == bsnl_pkg::DEPTH_CNT) ? bsnl_pkg::DEPTH_CNT - CW'(1) : wlen;
  assign out_load  = (state == bsnl_pkg::ST_DONE) && (!ovalid || rsp.ready);

  assign req.ready = (state == bsnl_pkg::ST_IDLE);

  // Working list and snapshot stores
  bsnl_ram #(.WIDTH($bits(bsnl_pkg::entry_t)), .DEPTH(bsnl_pkg::LIST_DEPTH)) u_working (
    .clk   (clk),
    .we    (wl_we),
    .waddr (wl_waddr),
    .wdata (wl_wdata),
    .re    (wl_re),
    .raddr (wl_raddr),
    .rdata (wl_rdata)
  );

  bsnl_ram #(.WIDTH($bits(bsnl_pkg::entry_t)), .DEPTH(bsnl_pkg::LIST_DEPTH)) u_snapshot (
    .clk   (clk),
    .we    (sn_we),
    .waddr (sn_waddr),
    .wdata (sn_wdata),
    .re    (sn_re),
    .raddr (sn_raddr),
    .rdata (sn_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bsnl_pkg::ST_IDLE: begin
        if (req.valid) begin
          case (req.action)
            bsnl_pkg::ACT_CLEAR:   state_next = bsnl_pkg::ST_DONE;
            bsnl_pkg::ACT_INSERT:  state_next = bsnl_pkg::ST_SEARCH;
            bsnl_pkg::ACT_PUBLISH: state_next = bsnl_pkg::ST_COPY;
            default: begin
              state_next = ({1'b0, req.read_index} < slen) ? bsnl_pkg::ST_READ
                                                            : bsnl_pkg::ST_DONE;
            end
          endcase
        end
      end
      bsnl_pkg::ST_SEARCH: begin
        if (lo != hi) begin
          state_next = bsnl_pkg::ST_COMPARE;
        end else if (lo == bsnl_pkg::DEPTH_CNT) begin
          state_next = bsnl_pkg::ST_DONE;
        end else begin
          state_next = bsnl_pkg::ST_SHIFT;
        end
      end
      bsnl_pkg::ST_COMPARE: state_next = bsnl_pkg::ST_SEARCH;
      bsnl_pkg::ST_SHIFT: begin
        if (!pend && ptr == lo) begin
          state_next = bsnl_pkg::ST_DONE;
        end
      end
      bsnl_pkg::ST_COPY: begin
        if (!pend && ptr == wlen) begin
          state_next = bsnl_pkg::ST_DONE;
        end
      end
      bsnl_pkg::ST_READ:    state_next = bsnl_pkg::ST_CAPTURE;
      bsnl_pkg::ST_CAPTURE: state_next = bsnl_pkg::ST_DONE;
      bsnl_pkg::ST_DONE: begin
        if (!ovalid || rsp.ready) begin
          state_next = bsnl_pkg::ST_IDLE;
        end
      end
      default: state_next = bsnl_pkg::ST_IDLE;
    endcase
  end

  // RAM port control per state
  always_comb begin
    wl_we    = 1'b0;
    wl_waddr = pend_addr;
    wl_wdata = wl_rdata;
    wl_re    = 1'b0;
    wl_raddr = mid[IW-1:0];
    sn_we    = 1'b0;
    sn_waddr = pend_addr;
    sn_wdata = wl_rdata;
    sn_re    = 1'b0;
    sn_raddr = ridx;
    case (state)
      bsnl_pkg::ST_SEARCH: begin
        wl_re = (lo != hi);
      end
      bsnl_pkg::ST_SHIFT: begin
        // moved entry lands one place up; the new entry goes in last
        if (pend) begin
          wl_we = 1'b1;
        end else if (ptr == lo) begin
          wl_we    = 1'b1;
          wl_waddr = lo[IW-1:0];
          wl_wdata = new_entry;
        end
        if (ptr > lo) begin
          wl_re    = 1'b1;
          wl_raddr = IW'(ptr - CW'(1));
        end
      end
      bsnl_pkg::ST_COPY: begin
        sn_we = pend;
        if (ptr < wlen) begin
          wl_re    = 1'b1;
          wl_raddr = ptr[IW-1:0];
        end
      end
      bsnl_pkg::ST_READ: begin
        sn_re = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bsnl_pkg::ST_IDLE;
      wlen   <= '0;
      slen   <= '0;
      pend   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        bsnl_pkg::ST_IDLE: begin
          pend <= 1'b0;
          if (req.valid && req.action == bsnl_pkg::ACT_CLEAR) begin
            wlen <= '0;
          end
        end
        bsnl_pkg::ST_SEARCH: begin
          if (lo == hi && lo != bsnl_pkg::DEPTH_CNT) begin
            wlen <= len_cap + CW'(1);
          end
        end
        bsnl_pkg::ST_SHIFT: pend <= (ptr > lo);
        bsnl_pkg::ST_COPY: begin
          pend <= (ptr < wlen);
          if (!pend && ptr == wlen) begin
            slen <= wlen;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bsnl_pkg::ST_IDLE: begin
        if (req.valid) begin
          new_entry.id  <= req.entity_id;
          new_entry.key <= req.distance_key;
          ridx          <= req.read_index;
          lo            <= '0;
          hi            <= wlen;
          ptr           <= '0;
          res_ins       <= 1'b0;
          res_pos       <= '0;
          res_rvalid    <= 1'b0;
          res_rid       <= '0;
          res_rkey      <= '0;
        end
      end
      bsnl_pkg::ST_SEARCH: begin
        if (lo == hi) begin
          res_pos <= lo;
          res_ins <= (lo != bsnl_pkg::DEPTH_CNT);
          ptr     <= len_cap;
        end
      end
      bsnl_pkg::ST_COMPARE: begin
        // upper bound: equal keys stay ahead of the new entry
        if (wl_rdata.key <= new_entry.key) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      bsnl_pkg::ST_SHIFT: begin
        if (ptr > lo) begin
          pend_addr <= ptr[IW-1:0];
          ptr       <= ptr - CW'(1);
        end
      end
      bsnl_pkg::ST_COPY: begin
        if (ptr < wlen) begin
          pend_addr <= ptr[IW-1:0];
          ptr       <= ptr + CW'(1);
        end
      end
      bsnl_pkg::ST_CAPTURE: begin
        res_rvalid <= 1'b1;
        res_rid    <= sn_rdata.id;
        res_rkey   <= sn_rdata.key;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.inserted        <= res_ins;
      rsp.insert_position <= res_pos;
      rsp.working_count   <= wlen;
      rsp.snapshot_count  <= slen;
      rsp.read_valid      <= res_rvalid;
      rsp.read_entity     <= res_rid;
      rsp.read_distance   <= res_rkey;
    end
  end

  assign rsp.valid = ovalid;

  // Checks
  `BSNL_ASSERT_IMP(a_wlen_bound, 1'b1, wlen <= bsnl_pkg::DEPTH_CNT,
                   "working length over depth")
  `BSNL_ASSERT_IMP(a_search_order, state == bsnl_pkg::ST_SEARCH, lo <= hi,
                   "search bounds crossed")
  `BSNL_ASSERT_IMP(a_shift_gap, (state == bsnl_pkg::ST_SHIFT && pend),
                   ({1'b0, pend_addr} == ptr + CW'(1)),
                   "shift write not one above read")
  `BSNL_ASSERT_NXT(a_insert_start,
                   (req.valid && req.ready && req.action == bsnl_pkg::ACT_INSERT),
                   state == bsnl_pkg::ST_SEARCH, "insert did not start search")
  `BSNL_ASSERT_NXT(a_copy_len,
                   (state == bsnl_pkg::ST_COPY && state_next == bsnl_pkg::ST_DONE),
                   slen == wlen, "snapshot length not published")

endmodule

/* rtl/core/bsnl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the working list and the snapshot.
module bsnl_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* test/nearest_list_checker.sv */
// Checker for the bounded sorted nearest list: watches both channels, keeps its own
// copy of the working list and the snapshot, and compares every result against it.
// Depends on bsnl_pkg and the bsnl_req_if / bsnl_rsp_if interfaces.
`timescale 1ns / 100ps

module nearest_list_checker
  import bsnl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bsnl_req_if        req,
  bsnl_rsp_if        rsp,
  output int         error_count,
  output int         pending,
  output int         checked
);

  typedef struct packed {
    logic                inserted;
    logic [CNT_BITS-1:0] position;
    logic [CNT_BITS-1:0] work_count;
    logic [CNT_BITS-1:0] snap_count;
    logic                read_valid;
    logic [ID_BITS-1:0]  read_entity;
    logic [KEY_BITS-1:0] read_distance;
  } outcome_t;

  entry_t   work_list[LIST_DEPTH];
  entry_t   snap_list[LIST_DEPTH];
  int       work_len;
  int       snap_len;
  outcome_t awaited_outcomes[$];

  // Apply one item to the local list copy and return the result it should produce
  function automatic outcome_t list_outcome(act_t action, logic [ID_BITS-1:0] id,
                                            logic [KEY_BITS-1:0] key,
                                            logic [IDX_BITS-1:0] idx);
    outcome_t res;
    int       slot;
    int       i;
    res = '0;
    case (action)
      ACT_CLEAR: work_len = 0;
      ACT_INSERT: begin
        // upper bound: the new entry lands after every equal key
        slot = 0;
        while (slot < work_len && work_list[slot].key <= key) slot++;
        res.position = CNT_BITS'(slot);
        if (slot < LIST_DEPTH) begin
          // full list: the farthest entry falls off the end
          if (work_len >= LIST_DEPTH) work_len = LIST_DEPTH - 1;
          for (i = work_len; i > slot; i--) work_list[i] = work_list[i-1];
          work_list[slot].id  = id;
          work_list[slot].key = key;
          work_len++;
          res.inserted = 1'b1;
        end
      end
      ACT_PUBLISH: begin
        snap_list = work_list;
        snap_len  = work_len;
      end
      default: begin
        if (int'(idx) < snap_len) begin
          res.read_valid    = 1'b1;
          res.read_entity   = snap_list[idx].id;
          res.read_distance = snap_list[idx].key;
        end
      end
    endcase
    res.work_count = CNT_BITS'(work_len);
    res.snap_count = CNT_BITS'(snap_len);
    return res;
  endfunction

  // Compare finished results first, then record the item taken at the same edge
  always @(posedge clk) begin : watch
    outcome_t want;
    outcome_t got;
    if (rst) begin
      work_len = 0;
      snap_len = 0;
      awaited_outcomes.delete();
      foreach (work_list[k]) begin
        work_list[k] = '0;
        snap_list[k] = '0;
      end
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.inserted, rsp.insert_position, rsp.working_count, rsp.snapshot_count,
                rsp.read_valid, rsp.read_entity, rsp.read_distance};
        if (awaited_outcomes.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%t ERROR: result with none outstanding: %p", $realtime, got);
        end else begin
          want = awaited_outcomes.pop_front();
          checked++;
          if (got.inserted !== want.inserted || got.position !== want.position ||
              got.work_count !== want.work_count || got.snap_count !== want.snap_count ||
              got.read_valid !== want.read_valid || got.read_entity !== want.read_entity ||
              got.read_distance !== want.read_distance) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%t ERROR: result %0d differs", $realtime, checked);
              $display("  want ins=%0d pos=%0d wcnt=%0d scnt=%0d rv=%0d id=%0d key=%h",
                       want.inserted, want.position, want.work_count, want.snap_count,
                       want.read_valid, want.read_entity, want.read_distance);
              $display("  got  ins=%0d pos=%0d wcnt=%0d scnt=%0d rv=%0d id=%0d key=%h",
                       got.inserted, got.position, got.work_count, got.snap_count,
                       got.read_valid, got.read_entity, got.read_distance);
            end
          end
        end
      end
      if (req.valid && req.ready)
        awaited_outcomes.push_back(list_outcome(act_t'(req.action), req.entity_id,
                                                req.distance_key, req.read_index));
    end
    pending = awaited_outcomes.size();
  end

endmodule

/* test/testbench.sv */
// Top of the nearest list testbench: clock, reset, stimulus and the verdict.
// Depends on bsnl_pkg, the channel interfaces, the block itself and nearest_list_checker.
`timescale 1ns / 100ps

module testbench;
  import bsnl_pkg::*;

  localparam int ITEM_TARGET = 1300;

  logic clk;
  logic rst;
  int   error_count;
  int   pending;
  int   checked;
  int   sent;
  int   n_clear;
  int   n_insert;
  int   n_publish;
  int   n_read;
  int   burst_left;

  bsnl_req_if req_ch ();
  bsnl_rsp_if rsp_ch ();

  bounded_sorted_nearest_list dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  nearest_list_checker list_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .error_count (error_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: switches between stall patterns after spans of random length
  initial begin : receiver
    int mode;
    int span;
    int tick;
    rsp_ch.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 400);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= ((tick % 5) < 2);
          default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until taken; gaps between bursts follow acceptance
  task automatic send_item(act_t action, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key,
                           logic [IDX_BITS-1:0] idx);
    req_ch.valid        <= 1'b1;
    req_ch.action       <= action;
    req_ch.entity_id    <= id;
    req_ch.distance_key <= key;
    req_ch.read_index   <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    case (action)
      ACT_CLEAR:   n_clear++;
      ACT_INSERT:  n_insert++;
      ACT_PUBLISH: n_publish++;
      default:     n_read++;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Key families: full range, a few values with many ties, the extremes, coarse steps
  function automatic logic [KEY_BITS-1:0] pick_key(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 32'd1;
          2: return 32'hFFFF_FFFE;
          default: return '1;
        endcase
      end
      default: return $urandom & 32'hFFFF_0000;
    endcase
  endfunction

  // Clear, fill, publish, then read back; sometimes the clear is skipped
  task automatic fill_and_read();
    int n_fill;
    int n_rd;
    int key_mode;
    int fill_len;
    int i;
    if ($urandom_range(0, 3) != 0) begin
      send_item(ACT_CLEAR, ID_BITS'($urandom_range(0, 1023)), $urandom,
                IDX_BITS'($urandom_range(0, 63)));
      fill_len = 0;
    end else begin
      fill_len = 64;
    end
    n_fill   = ($urandom_range(0, 2) == 0) ? $urandom_range(64, 100) : $urandom_range(1, 40);
    key_mode = $urandom_range(0, 3);
    for (i = 0; i < n_fill; i++) begin
      send_item(ACT_INSERT, ID_BITS'($urandom_range(0, 1023)), pick_key(key_mode),
                IDX_BITS'($urandom_range(0, 63)));
      // a publish in the middle of a fill now and then
      if ($urandom_range(0, 49) == 0)
        send_item(ACT_PUBLISH, ID_BITS'($urandom_range(0, 1023)), $urandom,
                  IDX_BITS'($urandom_range(0, 63)));
    end
    if (fill_len == 0) fill_len = (n_fill > 64) ? 64 : n_fill;
    send_item(ACT_PUBLISH, ID_BITS'($urandom_range(0, 1023)), $urandom,
              IDX_BITS'($urandom_range(0, 63)));
    n_rd = $urandom_range(1, 12);
    for (i = 0; i < n_rd; i++)
      send_item(ACT_READ, ID_BITS'($urandom_range(0, 1023)), $urandom,
                IDX_BITS'(($urandom_range(0, 2) != 0) ? $urandom_range(0, fill_len - 1)
                                                      : $urandom_range(0, 63)));
  endtask

  // Stimulus
  initial begin : stimulus
    int i;
    int n_noise;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_CLEAR;
    req_ch.entity_id    <= '0;
    req_ch.distance_key <= '0;
    req_ch.read_index   <= '0;
    sent       = 0;
    n_clear    = 0;
    n_insert   = 0;
    n_publish  = 0;
    n_read     = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty snapshot, extremes, equal keys and duplicate ids, clear vs snapshot
    send_item(ACT_READ, 10'd0, '0, 6'd0);
    send_item(ACT_PUBLISH, 10'd0, '0, 6'd0);
    send_item(ACT_READ, 10'd1023, '1, 6'd63);
    send_item(ACT_INSERT, 10'd0, 32'h0000_0000, 6'd0);
    send_item(ACT_INSERT, 10'd1023, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_INSERT, 10'd5, 32'd5, 6'd0);
    send_item(ACT_INSERT, 10'd5, 32'd5, 6'd0);
    send_item(ACT_INSERT, 10'd6, 32'd5, 6'd0);
    send_item(ACT_INSERT, 10'd7, 32'h0000_0000, 6'd0);
    send_item(ACT_INSERT, 10'd512, 32'h8000_0000, 6'd0);
    send_item(ACT_PUBLISH, 10'd0, '0, 6'd0);
    for (i = 0; i < 7; i++)
      send_item(ACT_READ, 10'd0, '0, 6'(i));
    send_item(ACT_READ, 10'd0, '0, 6'd7);
    send_item(ACT_READ, 10'd0, '0, 6'd63);
    send_item(ACT_CLEAR, 10'd0, '0, 6'd0);
    send_item(ACT_READ, 10'd0, '0, 6'd3);
    send_item(ACT_PUBLISH, 10'd0, '0, 6'd0);
    send_item(ACT_READ, 10'd0, '0, 6'd0);

    // Random: mostly well-formed fill/publish/read sequences, some noise
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        n_noise = $urandom_range(1, 10);
        for (i = 0; i < n_noise; i++)
          send_item(act_t'($urandom_range(0, 3)), ID_BITS'($urandom_range(0, 1023)),
                    pick_key(0), IDX_BITS'($urandom_range(0, 63)));
      end else begin
        fill_and_read();
      end
    end

    // Drain: let the checker record the last item, then wait out every result
    @(posedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("Sent %0d items: %0d clears, %0d inserts, %0d publishes, %0d reads",
             sent, n_clear, n_insert, n_publish, n_read);
    $display("Compared %0d results, %0d mismatches", checked, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bsnl_pkg.sv
rtl/core/bsnl_if.sv
rtl/core/bsnl_ram.sv
rtl/core/bounded_sorted_nearest_list.sv
test/nearest_list_checker.sv
test/testbench.sv
